// ===== hw/rtl/varicode_character_decoder_core_defines.svh =====
// assertion macros shared by the varicode decoder rtl
`ifndef VARICODE_CHARACTER_DECODER_CORE_DEFINES_SVH
`define VARICODE_CHARACTER_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked assertion, quiet while reset is held
`define VCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion that also holds during reset
`define VCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define VCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/vcd_pkg.sv =====
// package: varicode table, widths and lookup handshake types
`timescale 1ns / 1ps

package vcd_pkg;

    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int SOFT_W            = 8;
    localparam int CHAR_W            = 8;
    localparam int ROM_W             = 12;
    localparam int ROM_DEPTH         = 256;

    localparam logic [ROM_W-1:0] VC_ROM [ROM_DEPTH] = '{
        12'h2AB, 12'h2DB, 12'h2ED, 12'h377, 12'h2EB, 12'h35F, 12'h2EF, 12'h2FD,
        12'h2FF, 12'h0EF, 12'h01D, 12'h36F, 12'h2DD, 12'h01F, 12'h375, 12'h3AB,
        12'h2F7, 12'h2F5, 12'h3AD, 12'h3AF, 12'h35B, 12'h36B, 12'h36D, 12'h357,
        12'h37B, 12'h37D, 12'h3B7, 12'h355, 12'h35D, 12'h3BB, 12'h2FB, 12'h37F,
        12'h001, 12'h1FF, 12'h15F, 12'h1F5, 12'h1DB, 12'h2D5, 12'h2BB, 12'h17F,
        12'h0FB, 12'h0F7, 12'h16F, 12'h1DF, 12'h075, 12'h035, 12'h057, 12'h1AF,
        12'h0B7, 12'h0BD, 12'h0ED, 12'h0FF, 12'h177, 12'h15B, 12'h16B, 12'h1AD,
        12'h1AB, 12'h1B7, 12'h0F5, 12'h1BD, 12'h1ED, 12'h055, 12'h1D7, 12'h2AF,
        12'h2BD, 12'h07D, 12'h0EB, 12'h0AD, 12'h0B5, 12'h077, 12'h0DB, 12'h0FD,
        12'h155, 12'h07F, 12'h1FD, 12'h17D, 12'h0D7, 12'h0BB, 12'h0DD, 12'h0AB,
        12'h0D5, 12'h1DD, 12'h0AF, 12'h06F, 12'h06D, 12'h157, 12'h1B5, 12'h15D,
        12'h175, 12'h17B, 12'h2AD, 12'h1F7, 12'h1EF, 12'h1FB, 12'h2BF, 12'h16D,
        12'h2DF, 12'h00B, 12'h05F, 12'h02F, 12'h02D, 12'h003, 12'h03D, 12'h05B,
        12'h02B, 12'h00D, 12'h1EB, 12'h0BF, 12'h01B, 12'h03B, 12'h00F, 12'h007,
        12'h03F, 12'h1BF, 12'h015, 12'h017, 12'h005, 12'h037, 12'h07B, 12'h06B,
        12'h0DF, 12'h05D, 12'h1D5, 12'h2B7, 12'h1BB, 12'h2B5, 12'h2D7, 12'h3B5,
        12'h3BD, 12'h3BF, 12'h3D5, 12'h3D7, 12'h3DB, 12'h3DD, 12'h3DF, 12'h3EB,
        12'h3ED, 12'h3EF, 12'h3F5, 12'h3F7, 12'h3FB, 12'h3FD, 12'h3FF, 12'h555,
        12'h557, 12'h55B, 12'h55D, 12'h55F, 12'h56B, 12'h56D, 12'h56F, 12'h575,
        12'h577, 12'h57B, 12'h57D, 12'h57F, 12'h5AB, 12'h5AD, 12'h5AF, 12'h5B5,
        12'h5B7, 12'h5BB, 12'h5BD, 12'h5BF, 12'h5D5, 12'h5D7, 12'h5DB, 12'h5DD,
        12'h5DF, 12'h5EB, 12'h5ED, 12'h5EF, 12'h5F5, 12'h5F7, 12'h5FB, 12'h5FD,
        12'h5FF, 12'h6AB, 12'h6AD, 12'h6AF, 12'h6B5, 12'h6B7, 12'h6BB, 12'h6BD,
        12'h6BF, 12'h6D5, 12'h6D7, 12'h6DB, 12'h6DD, 12'h6DF, 12'h6EB, 12'h6ED,
        12'h6EF, 12'h6F5, 12'h6F7, 12'h6FB, 12'h6FD, 12'h6FF, 12'h755, 12'h757,
        12'h75B, 12'h75D, 12'h75F, 12'h76B, 12'h76D, 12'h76F, 12'h775, 12'h777,
        12'h77B, 12'h77D, 12'h77F, 12'h7AB, 12'h7AD, 12'h7AF, 12'h7B5, 12'h7B7,
        12'h7BB, 12'h7BD, 12'h7BF, 12'h7D5, 12'h7D7, 12'h7DB, 12'h7DD, 12'h7DF,
        12'h7EB, 12'h7ED, 12'h7EF, 12'h7F5, 12'h7F7, 12'h7FB, 12'h7FD, 12'h7FF,
        12'hAAB, 12'hAAD, 12'hAAF, 12'hAB5, 12'hAB7, 12'hABB, 12'hABD, 12'hABF,
        12'hAD5, 12'hAD7, 12'hADB, 12'hADD, 12'hADF, 12'hAEB, 12'hAED, 12'hAEF,
        12'hAF5, 12'hAF7, 12'hAFB, 12'hAFD, 12'hAFF, 12'hB55, 12'hB57, 12'hB5B
    };

    // request from the word tracker to the table search
    typedef struct packed {
        logic start;
        logic hold;
    } t_lk_req;

    // search result, done pulses for one cycle
    typedef struct packed {
        logic              done;
        logic              found;
        logic [CHAR_W-1:0] character;
    } t_lk_rsp;

endpackage

// ===== hw/rtl/vcd_lookup.sv =====
// serial first-match search of the varicode table, one entry per cycle
`timescale 1ns / 1ps
`include "varicode_character_decoder_core_defines.svh"

module vcd_lookup #(
    parameter int MAX_CODE_BITS = vcd_pkg::MAX_CODE_BITS_DEF,
    parameter int TABLE_ENTRIES = vcd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vcd_pkg::t_lk_req         i_req,
    input  logic [MAX_CODE_BITS-1:0] i_code,
    output vcd_pkg::t_lk_rsp         o_rsp
);
    import vcd_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        LK_IDLE = 2'b01,
        LK_RUN  = 2'b10
    } t_lk_state;

    t_lk_state        r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             w_hit;
    logic             w_last;
    logic             w_stop;

    // the one shared comparator
    assign w_hit  = (MAX_CODE_BITS'(VC_ROM[8'(r_idx)]) == i_code);
    assign w_last = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign w_stop = (r_state == LK_RUN) && (w_hit || w_last);

    assign o_rsp.done      = w_stop && !i_req.hold;
    assign o_rsp.found     = w_hit;
    assign o_rsp.character = w_hit ? CHAR_W'(r_idx) : '0;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            LK_IDLE: begin
                if (i_req.start) begin
                    n_state = LK_RUN;
                    n_idx   = '0;
                end
            end
            LK_RUN: begin
                if (w_stop) begin
                    // result slot busy: keep pointing at the answer
                    if (!i_req.hold) begin
                        n_state = LK_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = LK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LK_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx <= n_idx;
    end

    `VCD_ASSERT(a_start_when_idle, i_clk, i_rst_n, i_req.start |-> (r_state == LK_IDLE), "search started while busy")
    `VCD_ASSERT(a_done_then_idle, i_clk, i_rst_n, o_rsp.done |=> (r_state == LK_IDLE), "search did not finish after done")
    `VCD_ASSERT(a_hold_freezes, i_clk, i_rst_n, (w_stop && i_req.hold) |=> ((r_state == LK_RUN) && $stable(r_idx)), "stalled search moved on")

endmodule

// ===== hw/rtl/varicode_character_decoder_core.sv =====
// varicode character decoder: word tracking, table search and result register
//
// input channel: one signed soft bit per transaction on i_soft_bit, with
// i_in_valid / o_in_ready. positive is a one, negative a zero, zero neither.
// output channel: o_character / o_found with o_out_valid / i_out_ready, one
// transaction per completed code word (two negative bits in a row).
// a bit that does not end a word gives no result.
// a bit that ends a word starts a serial table search, one entry per cycle
// through a single comparator: it stops at the first match or at the last
// entry, and a miss shows on the output with o_found low.
// o_in_ready stays low for the whole search.
// a finished result sits in the output register; the next bits are taken
// meanwhile, and a later search holds at its answer until the register frees.
// words of MAX_CODE_BITS bits or more are dropped with no output.
// reset (synchronous, active low) returns to idle with no word open and the
// output register empty.
`timescale 1ns / 1ps
`include "varicode_character_decoder_core_defines.svh"

module varicode_character_decoder_core #(
    parameter int MAX_CODE_BITS = vcd_pkg::MAX_CODE_BITS_DEF,
    parameter int TABLE_ENTRIES = vcd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [vcd_pkg::SOFT_W-1:0] i_soft_bit,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic        [vcd_pkg::CHAR_W-1:0] o_character,
    output logic                              o_found
);
    import vcd_pkg::*;

    localparam int BC_W = $clog2(MAX_CODE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_in_word, n_in_word;
    logic                     r_prev_neg, n_prev_neg;
    logic                     r_prev_pos, n_prev_pos;
    logic [MAX_CODE_BITS-1:0] r_code, n_code;
    logic [BC_W-1:0]          r_bit_count, n_bit_count;
    logic                     r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]        r_character, n_character;
    logic                     r_found, n_found;

    logic            w_accept;
    logic            w_neg;
    logic            w_pos;
    logic [BC_W-1:0] w_count_inc;
    t_lk_req         w_req;
    t_lk_rsp         w_rsp;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_neg       = i_soft_bit[SOFT_W-1];
    assign w_pos       = (i_soft_bit != '0) && !w_neg;
    assign w_count_inc = r_bit_count + 1'b1;

    assign w_req.start = w_accept && r_in_word && r_prev_neg && w_neg;
    assign w_req.hold  = r_out_valid && !i_out_ready;

    vcd_lookup #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_code  (r_code),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_in_word   = r_in_word;
        n_prev_neg  = r_prev_neg;
        n_prev_pos  = r_prev_pos;
        n_code      = r_code;
        n_bit_count = r_bit_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_in_word) begin
                        if (r_prev_neg && w_neg) begin
                            // end of word, r_code stays as the search key
                            n_state     = ST_SEARCH;
                            n_in_word   = 1'b0;
                            n_bit_count = '0;
                        end else begin
                            n_code      = {r_code[MAX_CODE_BITS-2:0], r_prev_pos};
                            n_bit_count = w_count_inc;
                            n_prev_neg  = w_neg;
                            n_prev_pos  = w_pos;
                            if (w_count_inc >= BC_W'(MAX_CODE_BITS)) begin
                                // overlong word is dropped
                                n_in_word   = 1'b0;
                                n_bit_count = '0;
                                n_code      = '0;
                            end
                        end
                    end else if (w_pos) begin
                        n_in_word   = 1'b1;
                        n_prev_neg  = 1'b0;
                        n_prev_pos  = 1'b1;
                        n_code      = '0;
                        n_bit_count = '0;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_rsp.done) begin
                    n_state = ST_IDLE;
                    n_code  = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_character = r_character;
        n_found     = r_found;
        if (w_rsp.done) begin
            n_out_valid = 1'b1;
            n_character = w_rsp.character;
            n_found     = w_rsp.found;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_word   <= 1'b0;
            r_prev_neg  <= 1'b0;
            r_prev_pos  <= 1'b0;
            r_code      <= '0;
            r_bit_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_word   <= n_in_word;
            r_prev_neg  <= n_prev_neg;
            r_prev_pos  <= n_prev_pos;
            r_code      <= n_code;
            r_bit_count <= n_bit_count;
            r_out_valid <= n_out_valid;
        end
        r_character <= n_character;
        r_found     <= n_found;
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_character;
    assign o_found     = r_found;

    `VCD_ASSERT(a_count_bounded, i_clk, i_rst_n, r_bit_count < BC_W'(MAX_CODE_BITS), "bit count reached the word limit")
    `VCD_ASSERT(a_idle_count_clear, i_clk, i_rst_n, !r_in_word |-> (r_bit_count == '0), "bit count left over outside a word")
    `VCD_ASSERT(a_done_in_search, i_clk, i_rst_n, w_rsp.done |-> (r_state == ST_SEARCH), "lookup result outside a search")
    `VCD_ASSERT(a_done_loads_out, i_clk, i_rst_n, w_rsp.done |=> r_out_valid, "lookup result not registered")

endmodule
